>>> src/cht_pkg.sv
// Package for the chained hash table engine.
// Holds field widths, operation and status codes, the sequencer state type and the remainder handshake types.
// No dependencies.
package cht_pkg;

  localparam int FUNC_W = 2;
  localparam int KEY_W = 31;
  localparam int VAL_W = 8;
  localparam int STAT_W = 2;
  localparam int CNT_W = 5;

  // Key is split into nibbles for the bucket remainder
  localparam int NIB_CNT = (KEY_W + 3) / 4;
  localparam int NIB_CW = (NIB_CNT > 1) ? $clog2(NIB_CNT) : 1;

  localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
  localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

  typedef enum logic [6:0] {
    ST_IDLE      = 7'b0000001,
    ST_HASH      = 7'b0000010,
    ST_HEAD_RD   = 7'b0000100,
    ST_HEAD_WAIT = 7'b0001000,
    ST_NODE      = 7'b0010000,
    ST_EXEC      = 7'b0100000,
    ST_LINK      = 7'b1000000
  } state_t;

  // Handshake between sequencer and remainder unit
  typedef struct packed {
    logic go;
  } mod_ctl_t;

  typedef struct packed {
    logic done;
  } mod_sts_t;

endpackage

>>> src/cht_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/cht_mod.sv
// Bucket remainder unit: key mod BUCKET_COUNT, one nibble per cycle, MSB first.
// Depends on cht_pkg.
module cht_mod import cht_pkg::*; #(
  parameter int BUCKET_COUNT = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mod_ctl_t             ctl,
  input  logic [KEY_W-1:0]     key,
  output mod_sts_t             sts,
  output logic [((BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1)-1:0] rem
);

  localparam int BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam int RW = $clog2(BUCKET_COUNT + 1);
  localparam int TW = RW + 4;
  localparam int PADW = NIB_CNT * 4;

  logic [PADW-1:0]   shreg;
  logic [NIB_CW-1:0] cnt;
  logic [RW-1:0]     r;
  logic              active;
  logic [TW-1:0]     t;
  logic [TW-1:0]     r_next;

  // Fold in one nibble, reduce by 8B, 4B, 2B, B
  always_comb begin
    t = {r, shreg[PADW-1 -: 4]};
    for (int k = 3; k >= 0; k--) begin
      if (t >= (TW'(BUCKET_COUNT) << k)) begin
        t = t - (TW'(BUCKET_COUNT) << k);
      end
    end
    r_next = t;
  end

  // Advance through the nibbles
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      sts.done <= 1'b0;
    end else begin
      sts.done <= 1'b0;
      if (ctl.go) begin
        active <= 1'b1;
        cnt <= '0;
        r <= '0;
        shreg <= PADW'(key);
      end else if (active) begin
        r <= r_next[RW-1:0];
        shreg <= shreg << 4;
        cnt <= cnt + 1'b1;
        if (cnt == NIB_CW'(NIB_CNT - 1)) begin
          active <= 1'b0;
          sts.done <= 1'b1;
        end
      end
    end
  end

  assign rem = BW'(r);

endmodule

>>> src/chained_hash_table_engine_unit.sv
// Top level of the chained hash table engine: sequencer, bucket head RAM,
// node RAM and free-node stack RAM. Depends on cht_pkg, cht_ram, cht_mod.
//
// One request is taken when start is high and busy is low. Busy stays high
// until the result appears on status, found_value and entry_count for one
// cycle with done high. After acceptance the sequencer waits in ST_HASH for
// the bucket remainder unit, which works through the key one nibble at a
// time, then reads the bucket head and walks the chain, reading one node per
// cycle from the node RAM and visiting at most POOL_NODES nodes. An insert
// that appends behind an existing node passes through ST_LINK for the
// second node RAM write. The receiver cannot stall. No clearing pass
// follows reset: bucket heads carry valid bits, and fresh nodes are
// handed out by a counter before recycled ones are popped from the stack.
module chained_hash_table_engine_unit import cht_pkg::*; #(
  parameter int BUCKET_COUNT = 7,
  parameter int POOL_NODES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [FUNC_W-1:0] func,
  input  logic [KEY_W-1:0]  key,
  input  logic [VAL_W-1:0]  new_value,
  output logic              done,
  output logic [STAT_W-1:0] status,
  output logic [VAL_W-1:0]  found_value,
  output logic [CNT_W-1:0]  entry_count
);

  localparam int BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam int NW = $clog2(POOL_NODES + 1);
  localparam int AW = $clog2(POOL_NODES);
  localparam int NDW = KEY_W + VAL_W + NW;
  localparam logic [NW-1:0] NULL_IDX = NW'(POOL_NODES);

  state_t state;

  logic [FUNC_W-1:0] op;
  logic [KEY_W-1:0]  op_key;
  logic [VAL_W-1:0]  op_val;
  logic [BW-1:0]     bucket;
  logic [BW-1:0]     rem;
  mod_ctl_t          mctl;
  mod_sts_t          msts;

  logic [BUCKET_COUNT-1:0] hvalid;
  logic                    head_we;
  logic [NW-1:0]           head_wdata;
  logic [NW-1:0]           head_q;
  logic [NW-1:0]           head_cur;

  logic             node_we;
  logic [AW-1:0]    node_waddr;
  logic [NDW-1:0]   node_wdata;
  logic [AW-1:0]    node_raddr;
  logic [NDW-1:0]   node_q;
  logic [KEY_W-1:0] nkey;
  logic [VAL_W-1:0] nval;
  logic [NW-1:0]    nlink;
  logic [NW-1:0]    nnext;

  logic          stk_we;
  logic [AW-1:0] stk_q;
  logic [NW-1:0] sp;
  logic [NW-1:0] fresh;
  logic          full;
  logic [NW-1:0] alloc;

  logic [NW-1:0]    cur;
  logic [NW-1:0]    visited;
  logic             hit;
  logic [VAL_W-1:0] hit_val;
  logic [NW-1:0]    hit_link;
  logic             tail_ok;
  logic [NW-1:0]    tail;
  logic [KEY_W-1:0] tail_key;
  logic [VAL_W-1:0] tail_val;
  logic [NW-1:0]    new_idx;
  logic [NW-1:0]    count;

  // Bucket remainder unit, loaded from the key port in the accepting cycle
  cht_mod #(.BUCKET_COUNT(BUCKET_COUNT)) u_mod (
    .clk(clk), .rst(rst), .ctl(mctl), .key(key), .sts(msts), .rem(rem)
  );

  // Bucket head memory
  cht_ram #(.WIDTH(NW), .DEPTH(BUCKET_COUNT)) u_head (
    .clk(clk), .we(head_we), .waddr(bucket), .wdata(head_wdata),
    .raddr(bucket), .rdata(head_q)
  );

  // Node memory: key, value, link
  cht_ram #(.WIDTH(NDW), .DEPTH(POOL_NODES)) u_node (
    .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
    .raddr(node_raddr), .rdata(node_q)
  );

  // Recycled node stack
  cht_ram #(.WIDTH(AW), .DEPTH(POOL_NODES)) u_stack (
    .clk(clk), .we(stk_we), .waddr(sp[AW-1:0]), .wdata(cur[AW-1:0]),
    .raddr(AW'(sp - 1'b1)), .rdata(stk_q)
  );

  assign nkey = node_q[NDW-1 -: KEY_W];
  assign nval = node_q[NW +: VAL_W];
  assign nlink = node_q[NW-1:0];
  assign nnext = (nlink < NULL_IDX) ? nlink : NULL_IDX;
  assign head_cur = hvalid[bucket] ? head_q : NULL_IDX;
  assign full = (fresh == NULL_IDX) && (sp == '0);
  assign alloc = (fresh < NULL_IDX) ? fresh : NW'(stk_q);
  assign mctl.go = (state == ST_IDLE) && start;
  assign busy = (state != ST_IDLE);
  assign entry_count = CNT_W'(count);

  // Memory access control
  always_comb begin
    node_raddr = cur[AW-1:0];
    node_we = 1'b0;
    node_waddr = tail[AW-1:0];
    node_wdata = {tail_key, tail_val, new_idx};
    head_we = 1'b0;
    head_wdata = alloc;
    stk_we = 1'b0;
    case (state)
      ST_HEAD_WAIT: node_raddr = head_cur[AW-1:0];
      ST_NODE:      node_raddr = nnext[AW-1:0];
      ST_EXEC: begin
        if (op == FUNC_INSERT && !hit && !full) begin
          node_we = 1'b1;
          node_waddr = alloc[AW-1:0];
          node_wdata = {op_key, op_val, NULL_IDX};
          head_we = !tail_ok;
        end else if (op == FUNC_DELETE && hit) begin
          node_we = tail_ok;
          node_wdata = {tail_key, tail_val, hit_link};
          head_we = !tail_ok;
          head_wdata = hit_link;
          stk_we = 1'b1;
        end
      end
      ST_LINK: node_we = 1'b1;
      default: ;
    endcase
  end

  // Sequencer: hash, walk the chain, apply the change, report
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      hvalid <= '0;
      sp <= '0;
      fresh <= '0;
      count <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (head_we) begin
        hvalid[bucket] <= 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            op <= func;
            op_key <= key;
            op_val <= new_value;
            state <= ST_HASH;
          end
        end
        ST_HASH: begin
          if (msts.done) begin
            bucket <= rem;
            state <= ST_HEAD_RD;
          end
        end
        ST_HEAD_RD: state <= ST_HEAD_WAIT;
        ST_HEAD_WAIT: begin
          cur <= head_cur;
          hit <= 1'b0;
          tail_ok <= 1'b0;
          tail <= NULL_IDX;
          visited <= '0;
          state <= (head_cur < NULL_IDX) ? ST_NODE : ST_EXEC;
        end
        ST_NODE: begin
          if (nkey == op_key) begin
            hit <= 1'b1;
            hit_val <= nval;
            hit_link <= nnext;
            state <= ST_EXEC;
          end else begin
            tail_ok <= 1'b1;
            tail <= cur;
            tail_key <= nkey;
            tail_val <= nval;
            cur <= nnext;
            visited <= visited + 1'b1;
            if (nnext == NULL_IDX || visited == NW'(POOL_NODES - 1)) begin
              state <= ST_EXEC;
            end
          end
        end
        ST_EXEC: begin
          status <= STAT_MISS;
          found_value <= '0;
          state <= ST_IDLE;
          done <= 1'b1;
          case (op)
            FUNC_SEARCH: begin
              if (hit) begin
                status <= STAT_OK;
                found_value <= hit_val;
              end
            end
            FUNC_INSERT: begin
              if (!hit) begin
                if (full) begin
                  status <= STAT_FULL;
                end else begin
                  status <= STAT_OK;
                  count <= count + 1'b1;
                  new_idx <= alloc;
                  if (fresh < NULL_IDX) begin
                    fresh <= fresh + 1'b1;
                  end else begin
                    sp <= sp - 1'b1;
                  end
                  if (tail_ok) begin
                    state <= ST_LINK;
                    done <= 1'b0;
                  end
                end
              end
            end
            FUNC_DELETE: begin
              if (hit) begin
                status <= STAT_OK;
                sp <= sp + 1'b1;
                if (count != '0) begin
                  count <= count - 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
        ST_LINK: begin
          done <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> src/cht_check.sv
// Port-level checker for the chained hash table engine, bound to the top level.
// Depends on cht_pkg.
module cht_check import cht_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic [STAT_W-1:0] status,
  input logic [VAL_W-1:0]  found_value,
  input logic [CNT_W-1:0]  entry_count
);

  // A result only ends a busy transaction
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without transaction");

  // Accepted transaction raises busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("busy not raised");

  // A result whose status is not OK returns a zero value
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != STAT_OK) |-> found_value == '0) else $error("stray value");

  // Count moves only inside a transaction
  a_count_stable: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $changed(entry_count)) |-> $past(busy))
    else $error("count changed without transaction");

endmodule

bind chained_hash_table_engine_unit cht_check u_cht_check (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .status(status), .found_value(found_value), .entry_count(entry_count)
);

>>> tb/sv/tb_chained_hash_table_engine_unit.sv
// Self-checking testbench for the chained hash table engine.
// Drives search, insert and delete transactions and checks every result
// against a key/value map predictor. Depends on cht_pkg and the engine RTL.
`timescale 1ns / 1ps

module tb_chained_hash_table_engine_unit;
  import cht_pkg::*;

  localparam int POOL = 16;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  value;
    logic [CNT_W-1:0]  count;
  } answer_t;

  // Predict table answers and compare them with the engine's results
  class table_scoreboard;
    logic [VAL_W-1:0] contents[logic [KEY_W-1:0]];
    answer_t pending[$];
    int unsigned fails;

    function new();
      fails = 0;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fails++;
    endtask

    // Apply one accepted transaction to the map and queue its answer
    function void note_request(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k,
                               logic [VAL_W-1:0] v);
      answer_t a;
      a.status = STAT_MISS;
      a.value = '0;
      if (f == FUNC_SEARCH) begin
        if (contents.exists(k)) begin
          a.status = STAT_OK;
          a.value = contents[k];
        end
      end else if (f == FUNC_INSERT) begin
        if (!contents.exists(k)) begin
          if (contents.num() >= POOL) begin
            a.status = STAT_FULL;
          end else begin
            contents[k] = v;
            a.status = STAT_OK;
          end
        end
      end else if (f == FUNC_DELETE) begin
        if (contents.exists(k)) begin
          contents.delete(k);
          a.status = STAT_OK;
        end
      end
      a.count = CNT_W'(contents.num());
      pending.push_back(a);
    endfunction

    task check_result(logic [STAT_W-1:0] s, logic [VAL_W-1:0] v, logic [CNT_W-1:0] c);
      answer_t a;
      if (pending.size() == 0) begin
        report("unexpected result", s, 0);
      end else begin
        a = pending.pop_front();
        if (s !== a.status) report("status", s, a.status);
        if (v !== a.value) report("found_value", v, a.value);
        if (c !== a.count) report("entry_count", c, a.count);
      end
    endtask
  endclass

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [FUNC_W-1:0] func;
  logic [KEY_W-1:0]  key;
  logic [VAL_W-1:0]  new_value;
  logic              done;
  logic [STAT_W-1:0] status;
  logic [VAL_W-1:0]  found_value;
  logic [CNT_W-1:0]  entry_count;

  table_scoreboard sb;
  logic [KEY_W-1:0] key_pool[24];
  int burst_left;

  chained_hash_table_engine_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func), .key(key),
    .new_value(new_value), .done(done), .status(status),
    .found_value(found_value), .entry_count(entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Check each result on the edge that ends its strobe cycle
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(status, found_value, entry_count);
  end

  // Present one transaction and hold it until the engine takes it
  task send_op(logic [FUNC_W-1:0] f, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    start <= 1'b1;
    func <= f;
    key <= k;
    new_value <= v;
    do @(posedge clk); while (busy);
    sb.note_request(f, k, v);
    // End a burst with a random gap
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 15);
    end
  endtask

  task drain_results();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 9) == 0) return KEY_W'($urandom);
    return key_pool[$urandom_range(0, 23)];
  endfunction

  function automatic logic [FUNC_W-1:0] pick_func(int phase);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return FUNC_W'(3);
    // Lean toward filling, then toward emptying
    if (phase == 0) return (r < 60) ? FUNC_INSERT : (r < 80) ? FUNC_SEARCH : FUNC_DELETE;
    if (phase == 1) return (r < 30) ? FUNC_INSERT : (r < 60) ? FUNC_SEARCH : FUNC_DELETE;
    return (r < 40) ? FUNC_INSERT : (r < 70) ? FUNC_SEARCH : FUNC_DELETE;
  endfunction

  initial begin
    sb = new();
    rst = 1'b1;
    start = 1'b0;
    func = FUNC_SEARCH;
    key = '0;
    new_value = '0;
    burst_left = 0;
    // Keys crowd a few buckets; some sit at the top of the key range
    for (int i = 0; i < 12; i++) key_pool[i] = KEY_W'(7 * i + (i % 3));
    for (int i = 0; i < 12; i++) key_pool[12 + i] = {KEY_W{1'b1}} - KEY_W'(7 * i);
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, extremes, duplicate, unused code, full pool
    send_op(FUNC_SEARCH, '0, '0);
    send_op(FUNC_DELETE, '0, '0);
    send_op(FUNC_INSERT, '0, 8'hFF);
    send_op(FUNC_INSERT, {KEY_W{1'b1}}, 8'h00);
    send_op(FUNC_INSERT, '0, 8'h12);
    send_op(FUNC_SEARCH, '0, '0);
    send_op(FUNC_SEARCH, {KEY_W{1'b1}}, 8'hFF);
    send_op(FUNC_W'(3), '0, 8'hAA);
    send_op(FUNC_W'(3), 31'h5555_5555, 8'h55);
    for (int i = 1; i <= 14; i++) send_op(FUNC_INSERT, KEY_W'(7 * i), 8'(i * 17));
    send_op(FUNC_INSERT, 31'd3, 8'h33);
    send_op(FUNC_INSERT, '0, 8'h44);
    send_op(FUNC_SEARCH, 31'd49, '0);
    send_op(FUNC_DELETE, 31'd49, '0);
    send_op(FUNC_INSERT, 31'd3, 8'h33);
    drain_results();
    for (int i = 14; i >= 0; i--) send_op(FUNC_DELETE, KEY_W'(7 * i), '0);
    send_op(FUNC_DELETE, {KEY_W{1'b1}}, '0);
    send_op(FUNC_DELETE, 31'd3, '0);

    // Random traffic in fill, churn and mixed phases
    for (int n = 0; n < 1100; n++) begin
      if (n == 550) drain_results();
      send_op(pick_func((n / 120) % 3), pick_key(), VAL_W'($urandom));
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (sb.fails == 0 && sb.pending.size() == 0) begin
      $display("chained_hash_table_engine_unit verification clean");
    end else begin
      $display("chained_hash_table_engine_unit verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("chained_hash_table_engine_unit verification failed");
    $finish;
  end

endmodule
